[rtl/lmrf_pkg.sv]
`default_nettype none

package lmrf_pkg;

  localparam int PIXEL_W     = 8;
  localparam int COLUMN_W    = 12;
  localparam int LANE_REG_W  = 6;
  localparam int ROW_REG_W   = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_LANE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 2'd1;

  localparam logic [LANE_REG_W-1:0] LANE_WIDTH_RESET = 6'd1;
  localparam logic [ROW_REG_W-1:0]  ROW_WIDTH_RESET  = 13'd640;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_start;
  } pixel_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]  mark_value;
    logic [COLUMN_W-1:0] column;
    logic                row_last;
  } mark_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
  } cfg_write_t;

  typedef struct packed {
    logic has_result;
    logic value_ok;
    logic mark_last;
  } seq_ctl_t;

endpackage

`default_nettype wire

[rtl/lmrf_stream_if.sv]
`default_nettype none

interface lmrf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/lmrf_ram.sv]
`default_nettype none

module lmrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/lmrf_cfg_regs.sv]
`default_nettype none

module lmrf_cfg_regs #(
  parameter int MAX_LANE_WIDTH = 63,
  parameter int MAX_ROW_WIDTH  = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  lmrf_stream_if.sink                              cfg,
  output      logic [$clog2(MAX_LANE_WIDTH+1)-1:0] eff_lane,
  output      logic [$clog2(MAX_ROW_WIDTH):0]      eff_width
);

  localparam int LW = $clog2(MAX_LANE_WIDTH + 1);
  localparam int WW = $clog2(MAX_ROW_WIDTH) + 1;

  logic [lmrf_pkg::LANE_REG_W-1:0] lane_width;
  logic [lmrf_pkg::ROW_REG_W-1:0]  row_width;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_width <= lmrf_pkg::LANE_WIDTH_RESET;
      row_width  <= lmrf_pkg::ROW_WIDTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        lmrf_pkg::REG_LANE_WIDTH: lane_width <= cfg.data.value[lmrf_pkg::LANE_REG_W-1:0];
        lmrf_pkg::REG_ROW_WIDTH:  row_width  <= cfg.data.value[lmrf_pkg::ROW_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lane_width == '0) begin
      eff_lane = LW'(1);
    end else if (32'(lane_width) > 32'(MAX_LANE_WIDTH)) begin
      eff_lane = LW'(MAX_LANE_WIDTH);
    end else begin
      eff_lane = LW'(lane_width);
    end
  end

  always_comb begin
    if (row_width == '0) begin
      eff_width = WW'(1);
    end else if (32'(row_width) > 32'(MAX_ROW_WIDTH)) begin
      eff_width = WW'(MAX_ROW_WIDTH);
    end else begin
      eff_width = WW'(row_width);
    end
  end

endmodule

`default_nettype wire

[rtl/lmrf_result_seq.sv]
`default_nettype none

module lmrf_result_seq #(
  parameter int COL_W = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire lmrf_pkg::seq_ctl_t           ctl,
  input  wire logic [COL_W-1:0]             first_col,
  input  wire logic [COL_W-1:0]             last_col,
  input  wire logic [lmrf_pkg::PIXEL_W-1:0] side_pixel,
  input  wire logic [lmrf_pkg::PIXEL_W-1:0] center_pixel,
  input  wire logic [lmrf_pkg::PIXEL_W-1:0] far_pixel,
  output      logic                         take_ok,
  lmrf_stream_if.source                     marks
);

  logic                         busy;
  logic                         val_pend;
  logic                         mark_last;
  logic [COL_W-1:0]             col;
  logic [COL_W-1:0]             col_end;
  logic [lmrf_pkg::PIXEL_W-1:0] rgt;

  logic                         can_emit;
  logic                         emit;
  logic                         at_end;
  logic [lmrf_pkg::PIXEL_W-1:0] side_max;
  logic [lmrf_pkg::PIXEL_W-1:0] diff;
  logic [lmrf_pkg::PIXEL_W-1:0] ridge;

  assign can_emit = !marks.valid || marks.ready;
  assign emit     = busy && can_emit;
  assign at_end   = (col == col_end);
  assign take_ok  = !busy || (emit && at_end);

  always_comb begin
    side_max = (far_pixel > rgt) ? far_pixel : rgt;
    diff     = center_pixel - side_max;
    if (center_pixel <= side_max) begin
      ridge = '0;
    end else if (diff[lmrf_pkg::PIXEL_W-1]) begin
      ridge = lmrf_pkg::PIXEL_MAX;
    end else begin
      ridge = {diff[lmrf_pkg::PIXEL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      marks.valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= ctl.has_result;
      end else if (emit && at_end) begin
        busy <= 1'b0;
      end
      if (emit) begin
        marks.valid <= 1'b1;
      end else if (marks.ready) begin
        marks.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col       <= first_col;
      col_end   <= last_col;
      val_pend  <= ctl.value_ok;
      mark_last <= ctl.mark_last;
      rgt       <= side_pixel;
    end else if (emit) begin
      val_pend <= 1'b0;
      if (!at_end) begin
        col <= col + COL_W'(1);
      end
    end
    if (emit) begin
      marks.data <= '{mark_value: (val_pend ? ridge : '0),
                      column:     lmrf_pkg::COLUMN_W'(col),
                      row_last:   (mark_last && at_end)};
    end
  end

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> col <= col_end)
    else $error("result column ran past the end of its sequence");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> take_ok)
    else $error("new transaction loaded over a pending sequence");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    emit && at_end && mark_last |=> marks.valid && marks.data.row_last)
    else $error("row end not marked on its final result");
`endif

endmodule

`default_nettype wire

[rtl/lane_marking_row_filter_top.sv]
`default_nettype none

// Horizontal ridge filter for lane markings. Gray pixels enter on "pixels" in raster order,
// one per clock while "pixels" is ready; for column k of a row the result 2*p[k] - p[k-L] -
// p[k+L] - |p[k-L] - p[k+L]|, clamped to 0..255, leaves on "marks" once pixel k+L is taken
// (border columns give 0). A pixel that ends a row also flushes the pending columns as zeros,
// the last one marked with row_last; that pixel yields up to L+1 results, one per clock from
// the single result sequencer while "marks" is ready, so "pixels" is held not ready until the
// last of them is issued. The last 2*MAX_LANE_WIDTH+1 pixels sit in two copies of a RAM so the
// center tap and the far side tap read in the same cycle; the near side tap is the incoming
// pixel. Configuration writes on "cfg" are always taken.
module lane_marking_row_filter_top #(
  parameter int MAX_LANE_WIDTH = 63,
  parameter int MAX_ROW_WIDTH  = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lmrf_stream_if.sink   pixels,
  lmrf_stream_if.source marks,
  lmrf_stream_if.sink   cfg
);

  localparam int WIN_DEPTH = 2 * MAX_LANE_WIDTH + 1;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int LW        = $clog2(MAX_LANE_WIDTH + 1);
  localparam int CW        = $clog2(MAX_ROW_WIDTH);

  logic [LW-1:0]   eff_lane;
  logic [CW:0]     eff_width;

  logic [CW-1:0]   col_count;
  logic [AW-1:0]   ptr;

  logic            accept;
  logic            take_ok;
  logic [CW-1:0]   c_cur;
  logic [CW-1:0]   k_col;
  logic [CW-1:0]   first_col;
  logic [CW-1:0]   last_col;
  logic            row_end;
  logic            has_main;
  logic            value_ok;
  lmrf_pkg::seq_ctl_t ctl;

  logic [AW:0]     ctr_sum;
  logic [AW:0]     far_sum;
  logic [AW-1:0]   ctr_addr;
  logic [AW-1:0]   far_addr;
  logic [lmrf_pkg::PIXEL_W-1:0] center_pixel;
  logic [lmrf_pkg::PIXEL_W-1:0] far_pixel;

  lmrf_cfg_regs #(
    .MAX_LANE_WIDTH (MAX_LANE_WIDTH),
    .MAX_ROW_WIDTH  (MAX_ROW_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .eff_lane  (eff_lane),
    .eff_width (eff_width)
  );

  assign pixels.ready = take_ok;
  assign accept       = pixels.valid && take_ok;

  always_comb begin
    c_cur     = pixels.data.row_start ? '0 : col_count;
    row_end   = ((CW+1)'(c_cur) + (CW+1)'(1)) >= eff_width;
    has_main  = 32'(c_cur) >= 32'(eff_lane);
    k_col     = c_cur - CW'(eff_lane);
    value_ok  = has_main && (32'(k_col) >= 32'(eff_lane)) && ((CW+1)'(c_cur) < eff_width);
    first_col = has_main ? k_col : '0;
    last_col  = row_end ? c_cur : k_col;
    ctl       = '{has_result: (has_main || row_end), value_ok: value_ok, mark_last: row_end};
  end

  always_comb begin
    ctr_sum  = {1'b0, ptr} + (AW+1)'(WIN_DEPTH) - (AW+1)'(eff_lane);
    far_sum  = {1'b0, ptr} + (AW+1)'(WIN_DEPTH) - (AW+1)'({eff_lane, 1'b0});
    ctr_addr = (ctr_sum >= (AW+1)'(WIN_DEPTH)) ? AW'(ctr_sum - (AW+1)'(WIN_DEPTH))
                                               : AW'(ctr_sum);
    far_addr = (far_sum >= (AW+1)'(WIN_DEPTH)) ? AW'(far_sum - (AW+1)'(WIN_DEPTH))
                                               : AW'(far_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      ptr       <= '0;
    end else if (accept) begin
      col_count <= row_end ? '0 : c_cur + CW'(1);
      ptr       <= (ptr == AW'(WIN_DEPTH - 1)) ? '0 : ptr + AW'(1);
    end
  end

  lmrf_ram #(
    .WIDTH (lmrf_pkg::PIXEL_W),
    .DEPTH (WIN_DEPTH)
  ) u_ram_center (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr),
    .wdata (pixels.data.pixel),
    .re    (accept),
    .raddr (ctr_addr),
    .rdata (center_pixel)
  );

  lmrf_ram #(
    .WIDTH (lmrf_pkg::PIXEL_W),
    .DEPTH (WIN_DEPTH)
  ) u_ram_far (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr),
    .wdata (pixels.data.pixel),
    .re    (accept),
    .raddr (far_addr),
    .rdata (far_pixel)
  );

  lmrf_result_seq #(
    .COL_W (CW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .ctl          (ctl),
    .first_col    (first_col),
    .last_col     (last_col),
    .side_pixel   (pixels.data.pixel),
    .center_pixel (center_pixel),
    .far_pixel    (far_pixel),
    .take_ok      (take_ok),
    .marks        (marks)
  );

`ifndef NO_ASSERTIONS
  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> col_count == '0)
    else $error("column count not cleared at row end");

  a_col_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !row_end |=> col_count == $past(c_cur) + CW'(1))
    else $error("column count did not advance by one");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= AW'(WIN_DEPTH - 1))
    else $error("window pointer outside the window");
`endif

endmodule

`default_nettype wire

[sim/lane_marking_row_filter_top_tb.sv]
`timescale 1ns / 1ps

module lane_marking_row_filter_top_tb;

  localparam int MAX_LANE      = 63;
  localparam int MAX_ROW       = 4096;
  localparam int WINDOW_DEPTH  = 2 * MAX_LANE + 1;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_LIMIT    = 2000;

  class ridge_tracker;
    logic [lmrf_pkg::PIXEL_W-1:0]    window [WINDOW_DEPTH];
    int unsigned                     next_column;
    logic [lmrf_pkg::LANE_REG_W-1:0] lane_reg;
    logic [lmrf_pkg::ROW_REG_W-1:0]  row_reg;
    lmrf_pkg::mark_item_t            pending_marks [$];
    int unsigned                     errors;

    function new();
      foreach (window[i]) window[i] = '0;
      next_column = 0;
      lane_reg    = lmrf_pkg::LANE_WIDTH_RESET;
      row_reg     = lmrf_pkg::ROW_WIDTH_RESET;
      errors      = 0;
    endfunction

    function void write_reg(lmrf_pkg::cfg_write_t w);
      if (w.index == lmrf_pkg::REG_LANE_WIDTH) begin
        lane_reg = w.value[lmrf_pkg::LANE_REG_W-1:0];
      end else if (w.index == lmrf_pkg::REG_ROW_WIDTH) begin
        row_reg = w.value[lmrf_pkg::ROW_REG_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return pending_marks.size();
    endfunction

    function void queue_mark(lmrf_pkg::mark_item_t m);
      pending_marks.insert(pending_marks.size(), m);
    endfunction

    function void take_pixel(lmrf_pkg::pixel_item_t item);
      int unsigned lane, width, c, k, first_flush;
      int          cen, lft, rgt, hi, v;
      bit          row_end;
      lane = (lane_reg == 0) ? 1 : ((lane_reg > MAX_LANE) ? MAX_LANE : lane_reg);
      width = (row_reg == 0) ? 1 : ((row_reg > MAX_ROW) ? MAX_ROW : row_reg);
      c = item.row_start ? 0 : next_column;
      row_end = (c + 1 >= width);
      window[c % WINDOW_DEPTH] = item.pixel;
      first_flush = 0;
      if (c >= lane) begin
        k = c - lane;
        v = 0;
        if (k >= lane && c < width) begin
          cen = window[k % WINDOW_DEPTH];
          lft = window[(k - lane) % WINDOW_DEPTH];
          rgt = window[c % WINDOW_DEPTH];
          hi  = (lft > rgt) ? lft : rgt;
          v   = 2 * (cen - hi);
          if (v < 0) v = 0;
          if (v > int'(lmrf_pkg::PIXEL_MAX)) v = int'(lmrf_pkg::PIXEL_MAX);
        end
        queue_mark(lmrf_pkg::mark_item_t'{mark_value: v[lmrf_pkg::PIXEL_W-1:0],
                                          column: k[lmrf_pkg::COLUMN_W-1:0],
                                          row_last: 1'b0});
        first_flush = k + 1;
      end
      if (row_end) begin
        for (int unsigned j = first_flush; j <= c; j++) begin
          queue_mark(lmrf_pkg::mark_item_t'{mark_value: '0,
                                            column: j[lmrf_pkg::COLUMN_W-1:0],
                                            row_last: (j == c)});
        end
        next_column = 0;
      end else begin
        next_column = c + 1;
      end
    endfunction

    function void check_mark(lmrf_pkg::mark_item_t got);
      lmrf_pkg::mark_item_t want;
      if (pending_marks.size() == 0) begin
        $display("%0t: unexpected mark value %0d column %0d row_last %0b", $time,
                 got.mark_value, got.column, got.row_last);
        errors++;
        return;
      end
      want = pending_marks[0];
      pending_marks.delete(0);
      if (got.mark_value !== want.mark_value) begin
        $display("%0t: mark_value expected %0d actual %0d", $time, want.mark_value,
                 got.mark_value);
        errors++;
      end
      if (got.column !== want.column) begin
        $display("%0t: column expected %0d actual %0d", $time, want.column, got.column);
        errors++;
      end
      if (got.row_last !== want.row_last) begin
        $display("%0t: row_last expected %0b actual %0b", $time, want.row_last,
                 got.row_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lmrf_stream_if #(.payload_t(lmrf_pkg::pixel_item_t)) pixel_ch ();
  lmrf_stream_if #(.payload_t(lmrf_pkg::mark_item_t))  mark_ch ();
  lmrf_stream_if #(.payload_t(lmrf_pkg::cfg_write_t))  cfg_ch ();

  lane_marking_row_filter_top DUT (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixel_ch),
    .marks  (mark_ch),
    .cfg    (cfg_ch)
  );

  ridge_tracker tracker = new();
  int unsigned  idle_cycles = 0;
  int unsigned  sender_quiet = 0;
  bit           hold_marks = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pixel(input logic [lmrf_pkg::PIXEL_W-1:0] value, input logic start);
    int unsigned gap;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.data  <= lmrf_pkg::pixel_item_t'{pixel: value, row_start: start};
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  task automatic write_reg(input logic [lmrf_pkg::CFG_INDEX_W-1:0] index,
                           input logic [lmrf_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lmrf_pkg::cfg_write_t'{index: index, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    pixel_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_row_burst(input int unsigned count, input bit broken);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(lmrf_pkg::PIXEL_W'($urandom_range(0, 255)),
                 (i == 0) || (broken && $urandom_range(0, 15) == 0));
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned gap;
    int unsigned quiet;
    bit          held;
    quiet = 0;
    held  = 1'b0;
    mark_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_marks && !held) begin
        mark_ch.ready <= 1'b0;
        held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mark_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap(quiet);
      if (gap > 0) begin
        mark_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.data);
      if (pixel_ch.valid && pixel_ch.ready) tracker.take_pixel(pixel_ch.data);
      if (mark_ch.valid && mark_ch.ready) tracker.check_mark(mark_ch.data);
      if ((cfg_ch.valid && cfg_ch.ready) || (pixel_ch.valid && pixel_ch.ready) ||
          (mark_ch.valid && mark_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("lane_marking_row_filter_top: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned lane, width;
    rst            <= 1'b1;
    pixel_ch.valid <= 1'b0;
    pixel_ch.data  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero offset, short row, wrap into the next row, early row start
    write_reg(lmrf_pkg::REG_LANE_WIDTH, 13'd0);
    write_reg(lmrf_pkg::REG_ROW_WIDTH, 13'd5);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h3C, 1'b1);
    settle();

    // zero width acts as one pixel per row
    write_reg(lmrf_pkg::REG_ROW_WIDTH, 13'd0);
    send_pixel(8'hC3, 1'b0);
    send_pixel(8'h7E, 1'b0);
    settle();

    // offset above the field and width above the maximum, then shrink mid-row
    write_reg(lmrf_pkg::REG_LANE_WIDTH, 13'h7F);
    write_reg(lmrf_pkg::REG_ROW_WIDTH, 13'h1FFF);
    send_pixel(8'h12, 1'b1);
    send_pixel(8'hED, 1'b0);
    send_pixel(8'h01, 1'b0);
    settle();
    write_reg(lmrf_pkg::REG_ROW_WIDTH, 13'd2);
    send_pixel(8'hFE, 1'b0);
    settle();

    // offset changed mid-row
    write_reg(lmrf_pkg::REG_LANE_WIDTH, 13'd2);
    write_reg(lmrf_pkg::REG_ROW_WIDTH, 13'd12);
    send_pixel(8'h10, 1'b1);
    send_pixel(8'h20, 1'b0);
    send_pixel(8'hF0, 1'b0);
    send_pixel(8'h30, 1'b0);
    send_pixel(8'h40, 1'b0);
    settle();
    write_reg(lmrf_pkg::REG_LANE_WIDTH, 13'd1);
    send_pixel(8'h90, 1'b0);
    send_pixel(8'h05, 1'b0);
    send_pixel(8'hC0, 1'b0);
    settle();
    write_reg(lmrf_pkg::REG_LANE_WIDTH, 13'd3);
    send_pixel(8'h08, 1'b0);
    send_pixel(8'hE0, 1'b0);
    send_pixel(8'h02, 1'b0);
    settle();

    // widest offset: the row end flushes MAX_LANE+1 columns
    write_reg(lmrf_pkg::REG_LANE_WIDTH, lmrf_pkg::CFG_DATA_W'(MAX_LANE));
    write_reg(lmrf_pkg::REG_ROW_WIDTH, 13'd64);
    send_row_burst(64, 1'b0);
    settle();

    for (int ph = 1; ph <= 4; ph++) begin
      lane  = $urandom_range(1, 6);
      width = (ph == 2) ? MAX_ROW : $urandom_range(1, 24);
      write_reg(lmrf_pkg::REG_LANE_WIDTH, lmrf_pkg::CFG_DATA_W'(lane));
      write_reg(lmrf_pkg::REG_ROW_WIDTH, lmrf_pkg::CFG_DATA_W'(width));
      if (ph == 1) hold_marks = 1'b1;
      send_row_burst((ph == 1) ? 14 : 4, 1'b1);
      settle();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("lane_marking_row_filter_top: match");
    end else begin
      $display("%0t: %0d errors, %0d results missing", $time, tracker.errors,
               tracker.pending());
      $display("lane_marking_row_filter_top: mismatch");
    end
    $finish;
  end

endmodule
